/* hdl/tun_pkg.sv */
// Shared constants, types and helpers for the triangle unit normal block.
`timescale 1ns / 1ps

package tun_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 14;
    localparam int OUT_W      = 16;

    localparam int EDGE_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * EDGE_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int MAG_W      = CROSS_W;
    localparam int LO_W       = (MAG_W + 1) / 2;
    localparam int HI_W       = MAG_W - LO_W;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = SQ_W + 2;

    // quotient c^2 * 4^(F+1) / S never exceeds 4^(F+1)
    localparam int QUO_W      = 2 * FRAC_BITS + 3;
    localparam int ROOT_W     = (QUO_W + 1) / 2;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int SCALE_LAT  = QUO_W + ROOT_W + 1;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [CROSS_W-1:0]    t_cross;

    typedef struct packed {
        t_coord a_x;
        t_coord a_y;
        t_coord a_z;
        t_coord b_x;
        t_coord b_y;
        t_coord b_z;
        t_coord c_x;
        t_coord c_y;
        t_coord c_z;
    } t_verts;

    typedef struct packed {
        t_cross n_x;
        t_cross n_y;
        t_cross n_z;
        logic   degenerate;
    } t_tri;

    typedef struct packed {
        logic [FIFO_AW:0] count;
        logic             empty;
    } t_fifo_stat;

    typedef struct packed {
        logic       valid;
        logic       degenerate;
        logic [2:0] sign;
    } t_ctl;

endpackage

/* hdl/triangle_unit_normal.sv */
// Top level of the triangle unit normal block.
`timescale 1ns / 1ps

// Triangle unit normal. A start beat carries three vertices A, B, C; the block
// forms (C - A) x (B - A) and scales it to unit length, giving each component in
// signed Q1.14 (FRAC_BITS fraction bits), correctly rounded with ties away from
// zero. A zero cross product gives zero components with o_degenerate set.
// A new triangle is taken every cycle: the front end (edges, products, cross
// product) feeds an 8-deep queue, and the back end runs fully pipelined squares,
// a one-bit-per-stage divider and a one-bit-per-stage square root in three
// lanes. Each beat's result shows on o_done for exactly one cycle, in order.
// The receiver cannot stall, so the back end drains the queue every cycle and
// busy stays low under any start pattern; it exists only as queue-full
// protection.

module triangle_unit_normal (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [15:0] i_a_x,
    input  logic signed [15:0] i_a_y,
    input  logic signed [15:0] i_a_z,
    input  logic signed [15:0] i_b_x,
    input  logic signed [15:0] i_b_y,
    input  logic signed [15:0] i_b_z,
    input  logic signed [15:0] i_c_x,
    input  logic signed [15:0] i_c_y,
    input  logic signed [15:0] i_c_z,
    output logic        o_done,
    output logic signed [tun_pkg::OUT_W-1:0] o_norm_x,
    output logic signed [tun_pkg::OUT_W-1:0] o_norm_y,
    output logic signed [tun_pkg::OUT_W-1:0] o_norm_z,
    output logic        o_degenerate
);

    tun_pkg::t_verts     w_verts;
    tun_pkg::t_fifo_stat w_fifo;
    tun_pkg::t_tri       w_push_data;
    tun_pkg::t_tri       w_rd_data;
    logic                w_push;
    logic                w_pop;
    logic                w_rd_valid;

    // coordinates are read as COORD_BITS-bit two's complement
    assign w_verts.a_x = (tun_pkg::COORD_BITS)'(i_a_x);
    assign w_verts.a_y = (tun_pkg::COORD_BITS)'(i_a_y);
    assign w_verts.a_z = (tun_pkg::COORD_BITS)'(i_a_z);
    assign w_verts.b_x = (tun_pkg::COORD_BITS)'(i_b_x);
    assign w_verts.b_y = (tun_pkg::COORD_BITS)'(i_b_y);
    assign w_verts.b_z = (tun_pkg::COORD_BITS)'(i_b_z);
    assign w_verts.c_x = (tun_pkg::COORD_BITS)'(i_c_x);
    assign w_verts.c_y = (tun_pkg::COORD_BITS)'(i_c_y);
    assign w_verts.c_z = (tun_pkg::COORD_BITS)'(i_c_z);

    tun_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_verts (w_verts),
        .i_fifo  (w_fifo),
        .o_busy  (busy),
        .o_push  (w_push),
        .o_tri   (w_push_data)
    );

    tun_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_data     (w_push_data),
        .i_pop      (w_pop),
        .o_stat     (w_fifo),
        .o_rd_valid (w_rd_valid),
        .o_rd_data  (w_rd_data)
    );

    tun_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fifo       (w_fifo),
        .i_rd_valid   (w_rd_valid),
        .i_rd_data    (w_rd_data),
        .o_pop        (w_pop),
        .o_done       (o_done),
        .o_norm_x     (o_norm_x),
        .o_norm_y     (o_norm_y),
        .o_norm_z     (o_norm_z),
        .o_degenerate (o_degenerate)
    );

`ifndef SYNTHESIS
    // degenerate beat must come out as the zero vector
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_degenerate) |-> (o_norm_x == '0) && (o_norm_y == '0) && (o_norm_z == '0))
        else $error("degenerate result with nonzero components");

    // reset leaves no stray strobe and no backpressure
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done && !busy)
        else $error("strobe or busy right after reset");

    // back end drains every cycle, so the queue can never fill
    a_no_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("queue backed up");
`endif

endmodule

/* hdl/tun_front.sv */
// Front end: takes vertex beats, forms edges and the cross product, classifies degenerate.
`timescale 1ns / 1ps

module tun_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  tun_pkg::t_verts     i_verts,
    input  tun_pkg::t_fifo_stat i_fifo,
    output logic                o_busy,
    output logic                o_push,
    output tun_pkg::t_tri       o_tri
);

    logic r_v1, r_v2, r_v3;
    logic w_accept;
    logic [tun_pkg::FIFO_AW+1:0] w_load;

    logic signed [tun_pkg::EDGE_W-1:0] r_e1x, r_e1y, r_e1z, r_e2x, r_e2y, r_e2z;
    logic signed [tun_pkg::PROD_W-1:0] r_p_yz, r_p_zy, r_p_zx, r_p_xz, r_p_xy, r_p_yx;
    tun_pkg::t_cross w_nx, w_ny, w_nz;
    tun_pkg::t_tri   r_tri;

    // queue fill plus beats still in flight must leave room
    assign w_load = (tun_pkg::FIFO_AW + 2)'(i_fifo.count) + (tun_pkg::FIFO_AW + 2)'(r_v1)
                  + (tun_pkg::FIFO_AW + 2)'(r_v2) + (tun_pkg::FIFO_AW + 2)'(r_v3);
    assign o_busy   = w_load >= (tun_pkg::FIFO_AW + 2)'(tun_pkg::FIFO_DEPTH);
    assign w_accept = i_start & ~o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= w_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign w_nx = (tun_pkg::CROSS_W)'(r_p_yz) - (tun_pkg::CROSS_W)'(r_p_zy);
    assign w_ny = (tun_pkg::CROSS_W)'(r_p_zx) - (tun_pkg::CROSS_W)'(r_p_xz);
    assign w_nz = (tun_pkg::CROSS_W)'(r_p_xy) - (tun_pkg::CROSS_W)'(r_p_yx);

    always_ff @(posedge i_clk) begin
        r_e1x <= (tun_pkg::EDGE_W)'(i_verts.c_x) - (tun_pkg::EDGE_W)'(i_verts.a_x);
        r_e1y <= (tun_pkg::EDGE_W)'(i_verts.c_y) - (tun_pkg::EDGE_W)'(i_verts.a_y);
        r_e1z <= (tun_pkg::EDGE_W)'(i_verts.c_z) - (tun_pkg::EDGE_W)'(i_verts.a_z);
        r_e2x <= (tun_pkg::EDGE_W)'(i_verts.b_x) - (tun_pkg::EDGE_W)'(i_verts.a_x);
        r_e2y <= (tun_pkg::EDGE_W)'(i_verts.b_y) - (tun_pkg::EDGE_W)'(i_verts.a_y);
        r_e2z <= (tun_pkg::EDGE_W)'(i_verts.b_z) - (tun_pkg::EDGE_W)'(i_verts.a_z);

        r_p_yz <= (tun_pkg::PROD_W)'(r_e1y) * (tun_pkg::PROD_W)'(r_e2z);
        r_p_zy <= (tun_pkg::PROD_W)'(r_e1z) * (tun_pkg::PROD_W)'(r_e2y);
        r_p_zx <= (tun_pkg::PROD_W)'(r_e1z) * (tun_pkg::PROD_W)'(r_e2x);
        r_p_xz <= (tun_pkg::PROD_W)'(r_e1x) * (tun_pkg::PROD_W)'(r_e2z);
        r_p_xy <= (tun_pkg::PROD_W)'(r_e1x) * (tun_pkg::PROD_W)'(r_e2y);
        r_p_yx <= (tun_pkg::PROD_W)'(r_e1y) * (tun_pkg::PROD_W)'(r_e2x);

        r_tri.n_x        <= w_nx;
        r_tri.n_y        <= w_ny;
        r_tri.n_z        <= w_nz;
        r_tri.degenerate <= (w_nx == '0) && (w_ny == '0) && (w_nz == '0);
    end

    assign o_push = r_v3;
    assign o_tri  = r_tri;

endmodule

/* hdl/tun_fifo.sv */
// Short queue of classified cross products between front and back.
`timescale 1ns / 1ps

module tun_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tun_pkg::t_tri       i_data,
    input  logic                i_pop,
    output tun_pkg::t_fifo_stat o_stat,
    output logic                o_rd_valid,
    output tun_pkg::t_tri       o_rd_data
);

    tun_pkg::t_tri r_mem [tun_pkg::FIFO_DEPTH];
    tun_pkg::t_tri r_rd_data;
    logic [tun_pkg::FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [tun_pkg::FIFO_AW:0]   r_count, n_count;
    logic                        r_rd_valid;
    logic                        w_pop;

    assign w_pop   = i_pop & (r_count != '0);
    assign n_count = r_count + (tun_pkg::FIFO_AW + 1)'(i_push) - (tun_pkg::FIFO_AW + 1)'(w_pop);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
        if (w_pop) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count    <= n_count;
            r_rd_valid <= w_pop;
        end
    end

    assign o_stat.count = r_count;
    assign o_stat.empty = (r_count == '0);
    assign o_rd_valid   = r_rd_valid;
    assign o_rd_data    = r_rd_data;

endmodule

/* hdl/tun_scale.sv */
// One lane of the scaler: pipelined c^2*4^(F+1)/S divide, integer square root, rounding.
`timescale 1ns / 1ps

module tun_scale (
    input  logic                      i_clk,
    input  logic [tun_pkg::SQ_W-1:0]  i_c2,
    input  logic [tun_pkg::SUM_W-1:0] i_sum,
    output logic [tun_pkg::ROOT_W-1:0] o_q
);

    logic [tun_pkg::SUM_W-1:0]  r_rem  [tun_pkg::QUO_W];
    logic [tun_pkg::SUM_W-1:0]  r_div  [tun_pkg::QUO_W];
    logic [tun_pkg::QUO_W-1:0]  r_quo  [tun_pkg::QUO_W];

    logic [tun_pkg::ROOT_W+1:0] r_srem [tun_pkg::ROOT_W];
    logic [tun_pkg::ROOT_W-1:0] r_root [tun_pkg::ROOT_W];
    logic [tun_pkg::RAD_W-1:0]  r_rad  [tun_pkg::ROOT_W];

    logic [tun_pkg::ROOT_W:0]   w_t1;
    logic [tun_pkg::ROOT_W-1:0] r_q;

    // restoring divide, one quotient bit per stage; numerator is c^2 << (2F+2)
    for (genvar k = 0; k < tun_pkg::QUO_W; k++) begin : g_div
        logic [tun_pkg::SUM_W-1:0] w_prev;
        logic [tun_pkg::SUM_W-1:0] w_s;
        logic [tun_pkg::QUO_W-1:0] w_q;
        logic                      w_bit;
        logic [tun_pkg::SUM_W:0]   w_sh;
        logic [tun_pkg::SUM_W:0]   w_diff;
        logic                      w_ge;

        if (k == 0) begin : g_first
            assign w_prev = (tun_pkg::SUM_W)'(i_c2 >> 1);
            assign w_s    = i_sum;
            assign w_q    = '0;
            assign w_bit  = i_c2[0];
        end else begin : g_next
            assign w_prev = r_rem[k-1];
            assign w_s    = r_div[k-1];
            assign w_q    = r_quo[k-1];
            assign w_bit  = 1'b0;
        end

        assign w_sh   = {w_prev, w_bit};
        assign w_diff = w_sh - {1'b0, w_s};
        assign w_ge   = w_sh >= {1'b0, w_s};

        always_ff @(posedge i_clk) begin
            r_rem[k] <= w_ge ? w_diff[tun_pkg::SUM_W-1:0] : w_sh[tun_pkg::SUM_W-1:0];
            r_div[k] <= w_s;
            r_quo[k] <= {w_q[tun_pkg::QUO_W-2:0], w_ge};
        end
    end

    // digit-by-digit square root, one root bit per stage
    for (genvar j = 0; j < tun_pkg::ROOT_W; j++) begin : g_sqrt
        logic [tun_pkg::ROOT_W+1:0] w_prev;
        logic [tun_pkg::ROOT_W-1:0] w_root;
        logic [tun_pkg::RAD_W-1:0]  w_rad;
        logic [tun_pkg::ROOT_W+1:0] w_r;
        logic [tun_pkg::ROOT_W+1:0] w_trial;
        logic                       w_ge;

        if (j == 0) begin : g_first
            assign w_prev = '0;
            assign w_root = '0;
            assign w_rad  = (tun_pkg::RAD_W)'(r_quo[tun_pkg::QUO_W-1]);
        end else begin : g_next
            assign w_prev = r_srem[j-1];
            assign w_root = r_root[j-1];
            assign w_rad  = r_rad[j-1];
        end

        assign w_r     = {w_prev[tun_pkg::ROOT_W-1:0], w_rad[tun_pkg::RAD_W-1 -: 2]};
        assign w_trial = {w_root, 2'b01};
        assign w_ge    = w_r >= w_trial;

        always_ff @(posedge i_clk) begin
            r_srem[j] <= w_ge ? (w_r - w_trial) : w_r;
            r_root[j] <= {w_root[tun_pkg::ROOT_W-2:0], w_ge};
            r_rad[j]  <= w_rad << 2;
        end
    end

    // q = floor((isqrt(D) + 1) / 2): the largest q with (2q-1)^2 <= D
    assign w_t1 = (tun_pkg::ROOT_W + 1)'(r_root[tun_pkg::ROOT_W-1]) + 1'b1;

    always_ff @(posedge i_clk) begin
        r_q <= w_t1[tun_pkg::ROOT_W:1];
    end

    assign o_q = r_q;

endmodule

/* hdl/tun_back.sv */
// Back end: squares, sum of squares, three scaler lanes and the result register.
`timescale 1ns / 1ps

module tun_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tun_pkg::t_fifo_stat        i_fifo,
    input  logic                       i_rd_valid,
    input  tun_pkg::t_tri              i_rd_data,
    output logic                       o_pop,
    output logic                       o_done,
    output logic signed [tun_pkg::OUT_W-1:0] o_norm_x,
    output logic signed [tun_pkg::OUT_W-1:0] o_norm_y,
    output logic signed [tun_pkg::OUT_W-1:0] o_norm_z,
    output logic                       o_degenerate
);

    tun_pkg::t_cross w_n [3];

    tun_pkg::t_ctl r_c1, r_c2s, r_c3, r_c4;
    tun_pkg::t_ctl r_ctl [tun_pkg::SCALE_LAT];
    tun_pkg::t_ctl w_last;

    logic [tun_pkg::MAG_W-1:0]          r_mag [3];
    logic [2*tun_pkg::HI_W-1:0]         r_hh  [3];
    logic [tun_pkg::HI_W+tun_pkg::LO_W-1:0] r_hl [3];
    logic [2*tun_pkg::LO_W-1:0]         r_ll  [3];
    logic [tun_pkg::SQ_W-1:0]           r_sq  [3];
    logic [tun_pkg::SQ_W-1:0]           r_c2  [3];
    logic [tun_pkg::SUM_W-1:0]          r_sum;
    logic [tun_pkg::ROOT_W-1:0]         w_q   [3];
    logic signed [tun_pkg::ROOT_W:0]    w_v   [3];

    logic                               r_done, r_deg;
    logic signed [tun_pkg::OUT_W-1:0]   r_norm [3];

    assign o_pop = ~i_fifo.empty;

    assign w_n[0] = i_rd_data.n_x;
    assign w_n[1] = i_rd_data.n_y;
    assign w_n[2] = i_rd_data.n_z;

    // control line follows the data through every stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1  <= '0;
            r_c2s <= '0;
            r_c3  <= '0;
            r_c4  <= '0;
            for (int i = 0; i < tun_pkg::SCALE_LAT; i++) begin
                r_ctl[i] <= '0;
            end
        end else begin
            r_c1.valid      <= i_rd_valid;
            r_c1.degenerate <= i_rd_data.degenerate;
            r_c1.sign       <= {w_n[2][tun_pkg::CROSS_W-1], w_n[1][tun_pkg::CROSS_W-1],
                                w_n[0][tun_pkg::CROSS_W-1]};
            r_c2s    <= r_c1;
            r_c3     <= r_c2s;
            r_c4     <= r_c3;
            r_ctl[0] <= r_c4;
            for (int i = 1; i < tun_pkg::SCALE_LAT; i++) begin
                r_ctl[i] <= r_ctl[i-1];
            end
        end
    end

    assign w_last = r_ctl[tun_pkg::SCALE_LAT-1];

    for (genvar k = 0; k < 3; k++) begin : g_lane
        always_ff @(posedge i_clk) begin
            r_mag[k] <= (tun_pkg::MAG_W)'(w_n[k][tun_pkg::CROSS_W-1] ? -w_n[k] : w_n[k]);
            // split square: hi^2, hi*lo, lo^2
            r_hh[k] <= (2*tun_pkg::HI_W)'(r_mag[k][tun_pkg::MAG_W-1:tun_pkg::LO_W])
                     * (2*tun_pkg::HI_W)'(r_mag[k][tun_pkg::MAG_W-1:tun_pkg::LO_W]);
            r_hl[k] <= (tun_pkg::HI_W + tun_pkg::LO_W)'(r_mag[k][tun_pkg::MAG_W-1:tun_pkg::LO_W])
                     * (tun_pkg::HI_W + tun_pkg::LO_W)'(r_mag[k][tun_pkg::LO_W-1:0]);
            r_ll[k] <= (2*tun_pkg::LO_W)'(r_mag[k][tun_pkg::LO_W-1:0])
                     * (2*tun_pkg::LO_W)'(r_mag[k][tun_pkg::LO_W-1:0]);
            r_sq[k] <= ((tun_pkg::SQ_W)'(r_hh[k]) << (2 * tun_pkg::LO_W))
                     + ((tun_pkg::SQ_W)'(r_hl[k]) << (tun_pkg::LO_W + 1))
                     + (tun_pkg::SQ_W)'(r_ll[k]);
            r_c2[k] <= r_sq[k];
        end

        tun_scale u_scale (
            .i_clk (i_clk),
            .i_c2  (r_c2[k]),
            .i_sum (r_sum),
            .o_q   (w_q[k])
        );

        assign w_v[k] = w_last.sign[k] ? -$signed({1'b0, w_q[k]}) : $signed({1'b0, w_q[k]});
    end

    always_ff @(posedge i_clk) begin
        r_sum <= (tun_pkg::SUM_W)'(r_sq[0]) + (tun_pkg::SUM_W)'(r_sq[1])
               + (tun_pkg::SUM_W)'(r_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_deg <= w_last.degenerate;
        for (int i = 0; i < 3; i++) begin
            r_norm[i] <= w_last.degenerate ? '0 : (tun_pkg::OUT_W)'(w_v[i]);
        end
    end

    assign o_done       = r_done;
    assign o_degenerate = r_deg;
    assign o_norm_x     = r_norm[0];
    assign o_norm_y     = r_norm[1];
    assign o_norm_z     = r_norm[2];

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the triangle unit normal block.
`timescale 1ns / 1ps

// Drives triangles through the command port (start/busy), predicts each unit normal
// with exact wide-integer math, and checks every o_done beat against the oldest
// prediction. A short directed table comes first: degenerate cases, the six
// unit axes and coordinate extremes. Random triangles follow, in bursts
// with random gaps. The random mix covers full-range values, small values,
// collinear (degenerate) sets and extreme values. One drain pause falls mid-run.

module testbench;

    localparam int N_RANDOM   = 400;
    localparam int LATENCY    = 3 * tun_pkg::FRAC_BITS + 15;
    localparam int CYCLE_CAP  = 200000;

    typedef struct {
        logic signed [tun_pkg::OUT_W-1:0] nx;
        logic signed [tun_pkg::OUT_W-1:0] ny;
        logic signed [tun_pkg::OUT_W-1:0] nz;
        logic                             degen;
    } t_normal;

    typedef struct {
        tun_pkg::t_verts v;
        bit              typed;   // expected value given in the row
        t_normal         want;
    } t_row;

    logic   i_clk;
    logic   i_rst_n;
    logic   start;
    logic   busy;
    tun_pkg::t_verts drv;
    logic   o_done;
    logic signed [tun_pkg::OUT_W-1:0] o_norm_x, o_norm_y, o_norm_z;
    logic   o_degenerate;

    t_normal normal_q[$];
    t_normal typed_q[$];   // typed expectations, parallel to normal_q (all zero when unused)
    bit      typed_flag_q[$];
    t_row    rows[$];

    int n_accepted = 0;
    int n_checked  = 0;
    int n_degen    = 0;
    int n_errors   = 0;
    int cycles     = 0;
    bit row_typed;
    t_normal row_want;

    triangle_unit_normal i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_a_x       (drv.a_x),
        .i_a_y       (drv.a_y),
        .i_a_z       (drv.a_z),
        .i_b_x       (drv.b_x),
        .i_b_y       (drv.b_y),
        .i_b_z       (drv.b_z),
        .i_c_x       (drv.c_x),
        .i_c_y       (drv.c_y),
        .i_c_z       (drv.c_z),
        .o_done      (o_done),
        .o_norm_x    (o_norm_x),
        .o_norm_y    (o_norm_y),
        .o_norm_z    (o_norm_z),
        .o_degenerate(o_degenerate)
    );

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // Rounded magnitude of |c| * 2^F / sqrt(S), ties away from zero:
    // largest q with (2q-1)^2 * S <= 4 * c^2 * 4^F.
    function automatic logic [15:0] unit_component(input longint c, input logic [127:0] s);
        logic [127:0] cm, lim, odd;
        longint lo, hi, mid;
        cm  = (c < 0) ? -c : c;
        lim = (cm * cm) << (2 * tun_pkg::FRAC_BITS + 2);
        lo  = 0;
        hi  = longint'(1) << tun_pkg::FRAC_BITS;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            odd = 2 * mid - 1;
            if (odd * odd * s <= lim) lo = mid;
            else hi = mid - 1;
        end
        return (c < 0) ? 16'(-lo) : 16'(lo);
    endfunction

    function automatic t_normal face_normal(input tun_pkg::t_verts v);
        longint e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
        logic [127:0] sum;
        t_normal r;
        e1x = longint'(v.c_x) - v.a_x;  e2x = longint'(v.b_x) - v.a_x;
        e1y = longint'(v.c_y) - v.a_y;  e2y = longint'(v.b_y) - v.a_y;
        e1z = longint'(v.c_z) - v.a_z;  e2z = longint'(v.b_z) - v.a_z;
        nx = e1y * e2z - e1z * e2y;
        ny = e1z * e2x - e1x * e2z;
        nz = e1x * e2y - e1y * e2x;
        sum = 128'(nx < 0 ? -nx : nx) * 128'(nx < 0 ? -nx : nx)
            + 128'(ny < 0 ? -ny : ny) * 128'(ny < 0 ? -ny : ny)
            + 128'(nz < 0 ? -nz : nz) * 128'(nz < 0 ? -nz : nz);
        if (nx == 0 && ny == 0 && nz == 0) begin
            r = '{0, 0, 0, 1'b1};
        end else begin
            r.nx = unit_component(nx, sum);
            r.ny = unit_component(ny, sum);
            r.nz = unit_component(nz, sum);
            r.degen = 1'b0;
        end
        return r;
    endfunction

    // Accept on start && !busy, check each done beat against the oldest prediction.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && start && !busy) begin
            normal_q.push_back(face_normal(drv));
            typed_flag_q.push_back(row_typed);
            typed_q.push_back(row_want);
            n_accepted <= n_accepted + 1;
        end
        if (i_rst_n && o_done) begin
            if (normal_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result beat at cycle %0d", cycles);
            end else begin
                t_normal w, t;
                bit tf;
                w  = normal_q.pop_front();
                t  = typed_q.pop_front();
                tf = typed_flag_q.pop_front();
                // typed rows must agree with the predictor too
                if (tf && t != w) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("table row disagrees with predictor: %0d %0d %0d %0d",
                                 t.nx, t.ny, t.nz, t.degen);
                end
                if (o_norm_x !== w.nx || o_norm_y !== w.ny || o_norm_z !== w.nz
                    || o_degenerate !== w.degen) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch beat %0d: want %0d %0d %0d d%0d got %0d %0d %0d d%0d",
                                 n_checked, w.nx, w.ny, w.nz, w.degen,
                                 o_norm_x, o_norm_y, o_norm_z, o_degenerate);
                end
                if (w.degen) n_degen++;
                n_checked++;
            end
        end
        if (cycles > CYCLE_CAP) begin
            $display("timeout at cycle %0d", cycles);
            $display("[triangle_unit_normal] ERROR");
            $finish;
        end
    end

    function automatic tun_pkg::t_coord rand_coord(input int mode);
        int pick;
        unique case (mode)
            0: return tun_pkg::t_coord'($urandom_range(0, 65535));
            1: return tun_pkg::t_coord'(int'($urandom_range(0, 16)) - 8);
            default: begin
                pick = $urandom_range(0, 4);
                unique case (pick)
                    0: return -16'sd32768;
                    1: return 16'sd32767;
                    2: return 16'sd0;
                    3: return -16'sd1;
                    default: return 16'sd1;
                endcase
            end
        endcase
    endfunction

    function automatic tun_pkg::t_verts rand_triangle();
        tun_pkg::t_verts v;
        int mode, k, dx, dy, dz, ax, ay, az;
        mode = $urandom_range(0, 99);
        if (mode < 15) begin
            // collinear: C = A + k*(B - A), stays inside 16 bits
            ax = int'($urandom_range(0, 2000)) - 1000;
            ay = int'($urandom_range(0, 2000)) - 1000;
            az = int'($urandom_range(0, 2000)) - 1000;
            dx = int'($urandom_range(0, 200)) - 100;
            dy = int'($urandom_range(0, 200)) - 100;
            dz = int'($urandom_range(0, 200)) - 100;
            k  = int'($urandom_range(0, 10)) - 5;
            v = '{tun_pkg::t_coord'(ax), tun_pkg::t_coord'(ay), tun_pkg::t_coord'(az),
                  tun_pkg::t_coord'(ax + dx), tun_pkg::t_coord'(ay + dy),
                  tun_pkg::t_coord'(az + dz),
                  tun_pkg::t_coord'(ax + k * dx), tun_pkg::t_coord'(ay + k * dy),
                  tun_pkg::t_coord'(az + k * dz)};
        end else begin
            mode = (mode < 65) ? 0 : (mode < 85) ? 1 : 2;
            v = '{rand_coord(mode), rand_coord(mode), rand_coord(mode),
                  rand_coord(mode), rand_coord(mode), rand_coord(mode),
                  rand_coord(mode), rand_coord(mode), rand_coord(mode)};
        end
        return v;
    endfunction

    // Present one beat at a falling edge and hold it until accepted.
    task automatic send_triangle(input tun_pkg::t_verts v, input bit typed,
                                 input t_normal want);
        int target;
        target    = n_accepted + 1;
        drv       <= v;
        start     <= 1'b1;
        row_typed <= typed;
        row_want  <= want;
        do @(negedge i_clk); while (n_accepted < target);
    endtask

    task automatic pause_cycles(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (normal_q.size() != 0) @(negedge i_clk);
    endtask

    localparam tun_pkg::t_coord PMAX = 16'sd32767;
    localparam tun_pkg::t_coord NMAX = -16'sd32768;
    localparam int              ONE  = 1 << tun_pkg::FRAC_BITS;

    initial begin
        t_normal nochk;
        int burst;
        nochk     = '{0, 0, 0, 1'b0};
        start     = 1'b0;
        drv       = '0;
        row_typed = 1'b0;
        row_want  = nochk;
        i_rst_n   = 1'b0;

        // A, B, C; typed rows carry the obvious answer
        rows.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 1'b1}});
        rows.push_back('{'{PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX},
                         1, '{0, 0, 0, 1'b1}});
        rows.push_back('{'{NMAX, NMAX, NMAX, PMAX, PMAX, PMAX, 0, 0, 0},
                         1, '{0, 0, 0, 1'b1}});
        rows.push_back('{'{0, 0, 0, 0, 0, 1, 0, 1, 0}, 1, '{ONE, 0, 0, 1'b0}});
        rows.push_back('{'{0, 0, 0, 0, 1, 0, 0, 0, 1}, 1, '{-ONE, 0, 0, 1'b0}});
        rows.push_back('{'{0, 0, 0, 1, 0, 0, 0, 0, 1}, 1, '{0, ONE, 0, 1'b0}});
        rows.push_back('{'{0, 0, 0, 0, 0, 1, 1, 0, 0}, 1, '{0, -ONE, 0, 1'b0}});
        rows.push_back('{'{0, 0, 0, 0, 1, 0, 1, 0, 0}, 1, '{0, 0, ONE, 1'b0}});
        rows.push_back('{'{0, 0, 0, 1, 0, 0, 0, 1, 0}, 1, '{0, 0, -ONE, 1'b0}});
        // longest edges: both edges span the full coordinate range
        rows.push_back('{'{NMAX, NMAX, NMAX, PMAX, NMAX, NMAX, NMAX, PMAX, NMAX},
                         1, '{0, 0, -ONE, 1'b0}});
        rows.push_back('{'{PMAX, NMAX, 0, NMAX, PMAX, PMAX, PMAX, PMAX, NMAX}, 0, nochk});
        rows.push_back('{'{NMAX, PMAX, NMAX, PMAX, NMAX, PMAX, NMAX, NMAX, PMAX}, 0, nochk});
        rows.push_back('{'{0, 0, 0, 1, 1, 0, 0, 1, 1}, 0, nochk});
        rows.push_back('{'{0, 0, 0, 1, 2, 3, 4, 5, 6}, 0, nochk});
        rows.push_back('{'{-1, -1, -1, 2, -1, -1, -1, 3, -1}, 0, nochk});
        rows.push_back('{'{5, -7, 3, 5, -7, 3, 9, 0, 1}, 1, '{0, 0, 0, 1'b1}});
        rows.push_back('{'{0, 0, 0, 1, 1, 1, 1, 1, -2}, 0, nochk});
        rows.push_back('{'{100, 200, 300, -5, 7, 32000, PMAX, -9, 1}, 0, nochk});

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // back to back through the table
        foreach (rows[r]) send_triangle(rows[r].v, rows[r].typed, rows[r].want);
        wait_drained();

        for (int n = 0; n < N_RANDOM; ) begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
                send_triangle(rand_triangle(), 1'b0, nochk);
                if (n == N_RANDOM / 2) wait_drained();
            end
            pause_cycles($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
        end

        wait_drained();
        repeat (LATENCY + 10) @(negedge i_clk);

        $display("%0d triangles sent, %0d results checked, %0d of them degenerate",
                 n_accepted, n_checked, n_degen);
        $display("mix: axis and extreme rows, full-range, small, collinear; %0d errors",
                 n_errors);
        if (n_errors == 0 && normal_q.size() == 0) begin
            $display("[triangle_unit_normal] OK");
        end else begin
            $display("[triangle_unit_normal] ERROR");
        end
        $finish;
    end

endmodule
